// ----- hw/rtl/ipid_pkg.sv -----
// Shared types, constants and saturation and sign-extension helpers for the incremental PID core.
package ipid_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned WideW       = 64;
  localparam int unsigned DeadBandW   = 31;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned FracBitsDef = 16;

  localparam logic signed [DataW-1:0] OutMaxRst = 32'sd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCoefA0  = 3'd0,
    CfgCoefA1  = 3'd1,
    CfgCoefA2  = 3'd2,
    CfgDeadBnd = 3'd3,
    CfgOutMin  = 3'd4,
    CfgOutMax  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] coef_a0;
    logic signed [DataW-1:0] coef_a1;
    logic signed [DataW-1:0] coef_a2;
    logic [DeadBandW-1:0]    dead_band;
    logic signed [DataW-1:0] out_min;
    logic signed [DataW-1:0] out_max;
  } cfg_t;

  // Current error, the two earlier errors and the deadband decision.
  typedef struct packed {
    logic signed [DataW-1:0] e0;
    logic signed [DataW-1:0] e1;
    logic signed [DataW-1:0] e2;
    logic                    pass;
  } err_set_t;

  // Weighted and saturated terms of one step.
  typedef struct packed {
    logic signed [DataW-1:0] t0;
    logic signed [DataW-1:0] t1;
    logic signed [DataW-1:0] t2;
  } term_set_t;

  function automatic logic signed [DataW-1:0] sat_word(input logic signed [WideW-1:0] v);
    logic fits;
    fits = (&v[WideW-1:DataW-1]) || !(|v[WideW-1:DataW-1]);
    if (fits) begin
      return v[DataW-1:0];
    end else if (v[WideW-1]) begin
      return {1'b1, {(DataW-1){1'b0}}};
    end else begin
      return {1'b0, {(DataW-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [WideW-1:0] sext_word(input logic signed [DataW-1:0] v);
    return {{(WideW-DataW){v[DataW-1]}}, v};
  endfunction

endpackage

// ----- hw/rtl/incremental_pid_deadband_clamp_core.sv -----
// Top level of the incremental PID controller with deadband and output clamp.
//
//  Channel   Direction  Payload (low bit up)               Handshake
//  s_axis    in         setpoint[31:0], measured[63:32]    tvalid/tready
//  m_axis    out        drive[31:0]                        tvalid/tready
//  cfg       in         idx 0..5, 32-bit data              cfg_we_i, no wait
//
//  One request per cycle sustained while m_axis_tready is high; a result passes
//  the error, product and result registers. The rate is set by the last stage:
//  accumulate into the held output and clamp are combinational in one loop.
//  Reset clears valid bits, error history and held output and loads config defaults.
//  Each stage holds its contents while the stage after it is full; a waiting
//  result stalls a full pipe back to s_axis_tready in the same cycle, and up
//  to two requests behind it still enter empty stages.
module incremental_pid_deadband_clamp_core import ipid_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,   // setpoint[31:0], measured[63:32]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DataW-1:0]   m_axis_tdata,   // drive[31:0]
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_wdata_i
);

  cfg_t                    cfg;
  err_set_t                err_set;
  term_set_t               term_set;
  logic                    err_valid, err_ready;
  logic                    term_valid, term_ready;
  logic signed [DataW-1:0] drive;

  ipid_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  ipid_err_stage u_err (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .setpoint_i  (s_axis_tdata[DataW-1:0]),
    .measured_i  (s_axis_tdata[2*DataW-1:DataW]),
    .dead_band_i (cfg.dead_band),
    .valid_o     (err_valid),
    .ready_i     (err_ready),
    .err_o       (err_set)
  );

  ipid_mul_stage #(
    .FracBits (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (err_valid),
    .ready_o (err_ready),
    .err_i   (err_set),
    .cfg_i   (cfg),
    .valid_o (term_valid),
    .ready_i (term_ready),
    .term_o  (term_set)
  );

  ipid_acc_stage u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (term_valid),
    .ready_o (term_ready),
    .term_i  (term_set),
    .cfg_i   (cfg),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .drive_o (drive)
  );

  assign m_axis_tdata = drive;

endmodule

// ----- hw/rtl/ipid_cfg_regs.sv -----
// Configuration register file written through the plain write port.
module ipid_cfg_regs import ipid_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [CfgIdxW-1:0] idx_i,
  input  logic [DataW-1:0]   wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CfgCoefA0:  cfg_d.coef_a0   = wdata_i;
        CfgCoefA1:  cfg_d.coef_a1   = wdata_i;
        CfgCoefA2:  cfg_d.coef_a2   = wdata_i;
        CfgDeadBnd: cfg_d.dead_band = wdata_i[DeadBandW-1:0];
        CfgOutMin:  cfg_d.out_min   = wdata_i;
        CfgOutMax:  cfg_d.out_max   = wdata_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_a0   <= '0;
      cfg_q.coef_a1   <= '0;
      cfg_q.coef_a2   <= '0;
      cfg_q.dead_band <= '0;
      cfg_q.out_min   <= '0;
      cfg_q.out_max   <= OutMaxRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/ipid_err_stage.sv -----
// Input stage: error, deadband decision and error history shift.
module ipid_err_stage import ipid_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [DataW-1:0] setpoint_i,
  input  logic signed [DataW-1:0] measured_i,
  input  logic [DeadBandW-1:0]    dead_band_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output err_set_t                err_o
);

  logic                    valid_q, valid_d;
  err_set_t                err_q, err_d;
  logic signed [DataW-1:0] err_prev_q, err_prev_d;
  logic signed [DataW-1:0] err_prev2_q, err_prev2_d;
  logic signed [DataW-1:0] e0;
  logic [DataW-1:0]        mag;
  logic                    accept;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  assign e0  = sat_word(sext_word(setpoint_i) - sext_word(measured_i));
  // Magnitude of the most negative error is exactly 2^31 as unsigned.
  assign mag = e0[DataW-1] ? DataW'(-e0) : DataW'(e0);

  always_comb begin
    valid_d     = valid_q;
    err_d       = err_q;
    err_prev_d  = err_prev_q;
    err_prev2_d = err_prev2_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
    if (accept) begin
      err_d.e0    = e0;
      err_d.e1    = err_prev_q;
      err_d.e2    = err_prev2_q;
      err_d.pass  = (mag >= {1'b0, dead_band_i});
      err_prev_d  = e0;
      err_prev2_d = err_prev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      err_prev_q  <= '0;
      err_prev2_q <= '0;
    end else begin
      valid_q     <= valid_d;
      err_prev_q  <= err_prev_d;
      err_prev2_q <= err_prev2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= err_d;
  end

  assign valid_o = valid_q;
  assign err_o   = err_q;

  // History shifts exactly once per accepted request.
  a_hist_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (err_prev2_q == $past(err_prev_q)) && (err_q.e0 == err_prev_q))
    else $error("error history did not shift on accept");

  // A held request keeps its error set while the next stage is full.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> valid_q && $stable(err_q) && $stable(err_prev_q))
    else $error("stalled error stage lost its contents");

endmodule

// ----- hw/rtl/ipid_mul_stage.sv -----
// Product stage: three coefficient products, floor shift and saturation.
module ipid_mul_stage import ipid_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  err_set_t  err_i,
  input  cfg_t      cfg_i,
  output logic      valid_o,
  input  logic      ready_i,
  output term_set_t term_o
);

  logic                    valid_q, valid_d;
  term_set_t               term_q, term_d;
  logic signed [WideW-1:0] p0, p1, p2;

  assign ready_o = !valid_q || ready_i;

  assign p0 = sext_word(cfg_i.coef_a0) * sext_word(err_i.e0);
  assign p1 = sext_word(cfg_i.coef_a1) * sext_word(err_i.e1);
  assign p2 = sext_word(cfg_i.coef_a2) * sext_word(err_i.e2);

  always_comb begin
    valid_d = valid_q;
    term_d  = term_q;
    if (ready_o) begin
      valid_d = valid_i;
      // Zero every term inside the deadband.
      if (err_i.pass) begin
        term_d.t0 = sat_word(p0 >>> FracBits);
        term_d.t1 = sat_word(p1 >>> FracBits);
        term_d.t2 = sat_word(p2 >>> FracBits);
      end else begin
        term_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
  end

  assign valid_o = valid_q;
  assign term_o  = term_q;

endmodule

// ----- hw/rtl/ipid_acc_stage.sv -----
// Result stage: increment sum, saturating accumulate, clamp, output register.
module ipid_acc_stage import ipid_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  term_set_t               term_i,
  input  cfg_t                    cfg_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [DataW-1:0] drive_o
);

  logic                    valid_q, valid_d;
  logic signed [DataW-1:0] out_acc_q, out_acc_d;
  logic signed [DataW-1:0] drive_q, drive_d;
  logic signed [DataW-1:0] inc, acc_sat, acc_clamp;
  logic                    load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  assign inc     = sat_word(sext_word(term_i.t0) - sext_word(term_i.t1)
                            + sext_word(term_i.t2));
  assign acc_sat = sat_word(sext_word(out_acc_q) + sext_word(inc));

  always_comb begin
    // With inverted limits, a sum above out_max gets out_max, else out_min.
    priority if (acc_sat > cfg_i.out_max) begin
      acc_clamp = cfg_i.out_max;
    end else if (acc_sat < cfg_i.out_min) begin
      acc_clamp = cfg_i.out_min;
    end else begin
      acc_clamp = acc_sat;
    end
  end

  always_comb begin
    valid_d   = valid_q;
    out_acc_d = out_acc_q;
    drive_d   = drive_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
    if (load) begin
      out_acc_d = acc_clamp;
      drive_d   = acc_clamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      out_acc_q <= '0;
    end else begin
      valid_q   <= valid_d;
      out_acc_q <= out_acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drive_q <= drive_d;
  end

  assign valid_o = valid_q;
  assign drive_o = drive_q;

  // A waiting result always equals the held controller output.
  a_acc_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (drive_q == out_acc_q))
    else $error("result register differs from held output");

  // With ordered limits every result lies inside them.
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (cfg_i.out_min <= cfg_i.out_max)) |=>
      (drive_q >= $past(cfg_i.out_min)) && (drive_q <= $past(cfg_i.out_max)))
    else $error("result outside clamp limits");

endmodule
